// ===== sv/mfd_pkg.sv =====
// shared types, codes and constants for the mfm flux interval deserializer
`timescale 1ns / 1ps

package mfd_pkg;

    localparam int HIST_BINS_DEFAULT = 1024;

    localparam int TIME_W   = 32;
    localparam int BIN_W    = 10;
    localparam int LIMIT_W  = 10;
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 32;
    localparam int SHIFT_W  = 12;
    localparam int POS_W    = 3;
    localparam int CELLS_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam int BYTE_CELLS = 8;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_EDGE        = 2'd0;
    localparam logic [OP_W-1:0] OP_TRACK_START = 2'd1;
    localparam logic [OP_W-1:0] OP_HIST_READ   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RUNT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_THREE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FOUR  = 2'd3;

    localparam logic [LIMIT_W-1:0] RUNT_LIMIT_RESET  = 10'd240;
    localparam logic [LIMIT_W-1:0] LIMIT_TWO_RESET   = 10'd400;
    localparam logic [LIMIT_W-1:0] LIMIT_THREE_RESET = 10'd560;
    localparam logic [LIMIT_W-1:0] LIMIT_FOUR_RESET  = 10'd720;

    // histogram action codes
    localparam logic [1:0] HIST_NONE  = 2'd0;
    localparam logic [1:0] HIST_INC   = 2'd1;
    localparam logic [1:0] HIST_CLEAR = 2'd2;

    typedef struct packed {
        logic              valid;
        logic              has_result;
        logic              is_count;
        logic [BYTE_W-1:0] data_byte;
        logic [1:0]        hist_op;
    } mfd_stage_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic [BYTE_W-1:0]  data_byte;
        logic               is_count;
    } mfd_result_t;

endpackage

// ===== sv/mfd_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/mfd_edge_stage.sv =====
// input register, interval classing, cell shifter and threshold registers
`timescale 1ns / 1ps

module mfd_edge_stage #(
    parameter int HIST_BINS = mfd_pkg::HIST_BINS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [mfd_pkg::OP_W-1:0]          operation,
    input  logic [mfd_pkg::TIME_W-1:0]        edge_time,
    input  logic [mfd_pkg::BIN_W-1:0]         bin_index,
    input  logic                              cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mfd_pkg::LIMIT_W-1:0]       cfg_data,
    output logic                              s1_valid,
    output mfd_pkg::mfd_stage_t               stage_out,
    output logic [$clog2(HIST_BINS)-1:0]      hist_addr
);

    localparam int AW = $clog2(HIST_BINS);
    localparam int SW = ((AW > mfd_pkg::LIMIT_W) ? AW : mfd_pkg::LIMIT_W) + 1;
    localparam int RW = ((AW > mfd_pkg::BIN_W) ? AW : mfd_pkg::BIN_W) + 1;

    logic [mfd_pkg::LIMIT_W-1:0] runt_limit_reg;
    logic [mfd_pkg::LIMIT_W-1:0] limit_two_reg;
    logic [mfd_pkg::LIMIT_W-1:0] limit_three_reg;
    logic [mfd_pkg::LIMIT_W-1:0] limit_four_reg;

    logic [mfd_pkg::TIME_W-1:0]  last_edge_time_reg;
    logic [mfd_pkg::TIME_W-1:0]  diff;

    logic                        in_valid_reg;
    logic [mfd_pkg::OP_W-1:0]    op_reg;
    logic [mfd_pkg::BIN_W-1:0]   bin_reg;
    logic                        diff_small_reg;
    logic [AW-1:0]               diff_lo_reg;

    logic [mfd_pkg::LIMIT_W-1:0] pending_runt_reg;
    logic [mfd_pkg::LIMIT_W-1:0] pending_runt_next;
    logic [mfd_pkg::SHIFT_W-1:0] cell_shift_reg;
    logic [mfd_pkg::SHIFT_W-1:0] cell_shift_next;
    logic [mfd_pkg::POS_W-1:0]   cell_position_reg;
    logic [mfd_pkg::POS_W-1:0]   cell_position_next;

    logic [SW-1:0]               interval;
    logic                        in_range;
    logic [RW-1:0]               bin_ext;
    logic [mfd_pkg::CELLS_W-1:0] cells;
    logic [mfd_pkg::POS_W:0]     pos_sum;
    logic [mfd_pkg::SHIFT_W-1:0] byte_shift;

    assign diff = edge_time - last_edge_time_reg;

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runt_limit_reg  <= mfd_pkg::RUNT_LIMIT_RESET;
            limit_two_reg   <= mfd_pkg::LIMIT_TWO_RESET;
            limit_three_reg <= mfd_pkg::LIMIT_THREE_RESET;
            limit_four_reg  <= mfd_pkg::LIMIT_FOUR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mfd_pkg::CFG_RUNT_LIMIT:  runt_limit_reg  <= cfg_data;
                mfd_pkg::CFG_LIMIT_TWO:   limit_two_reg   <= cfg_data;
                mfd_pkg::CFG_LIMIT_THREE: limit_three_reg <= cfg_data;
                mfd_pkg::CFG_LIMIT_FOUR:  limit_four_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register, time difference taken on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            last_edge_time_reg <= '0;
        end
        else
        begin
            in_valid_reg <= accept;
            if (accept && (operation == mfd_pkg::OP_EDGE ||
                           operation == mfd_pkg::OP_TRACK_START))
            begin
                last_edge_time_reg <= edge_time;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= operation;
            bin_reg        <= bin_index;
            diff_small_reg <= (diff[mfd_pkg::TIME_W-1:AW] == '0);
            diff_lo_reg    <= diff[AW-1:0];
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_runt_reg  <= '0;
            cell_shift_reg    <= mfd_pkg::SHIFT_W'(1);
            cell_position_reg <= mfd_pkg::POS_W'(1);
        end
        else
        begin
            pending_runt_reg  <= pending_runt_next;
            cell_shift_reg    <= cell_shift_next;
            cell_position_reg <= cell_position_next;
        end
    end

    always_comb
    begin
        interval = SW'(diff_lo_reg) + SW'(pending_runt_reg);
        in_range = diff_small_reg && (interval < SW'(HIST_BINS));
        bin_ext  = RW'(bin_reg);

        pending_runt_next  = pending_runt_reg;
        cell_shift_next    = cell_shift_reg;
        cell_position_next = cell_position_reg;
        cells              = '0;
        pos_sum            = '0;
        byte_shift         = '0;

        stage_out.valid      = in_valid_reg;
        stage_out.has_result = 1'b0;
        stage_out.is_count   = 1'b0;
        stage_out.data_byte  = '0;
        stage_out.hist_op    = mfd_pkg::HIST_NONE;
        hist_addr            = bin_ext[AW-1:0];

        if (in_valid_reg)
        begin
            unique case (op_reg)
                mfd_pkg::OP_EDGE:
                begin
                    if (in_range)
                    begin
                        stage_out.hist_op = mfd_pkg::HIST_INC;
                        hist_addr         = interval[AW-1:0];
                        if (interval < SW'(runt_limit_reg))
                        begin
                            pending_runt_next = interval[mfd_pkg::LIMIT_W-1:0];
                        end
                        else
                        begin
                            pending_runt_next = '0;
                            if (interval < SW'(limit_two_reg))
                            begin
                                cells = 3'd2;
                            end
                            else if (interval < SW'(limit_three_reg))
                            begin
                                cells = 3'd3;
                            end
                            else if (interval < SW'(limit_four_reg))
                            begin
                                cells = 3'd4;
                            end
                            if (cells != '0)
                            begin
                                cell_shift_next = (cell_shift_reg << cells)
                                                  | mfd_pkg::SHIFT_W'(1);
                                pos_sum = {1'b0, cell_position_reg} + {1'b0, cells};
                                if (pos_sum >= (mfd_pkg::POS_W + 1)'(mfd_pkg::BYTE_CELLS))
                                begin
                                    cell_position_next = pos_sum[mfd_pkg::POS_W-1:0];
                                    byte_shift = cell_shift_next >> cell_position_next;
                                    stage_out.has_result = 1'b1;
                                    stage_out.data_byte  = byte_shift[mfd_pkg::BYTE_W-1:0];
                                end
                                else
                                begin
                                    cell_position_next = pos_sum[mfd_pkg::POS_W-1:0];
                                end
                            end
                        end
                    end
                end
                mfd_pkg::OP_TRACK_START:
                begin
                    pending_runt_next  = '0;
                    cell_shift_next    = mfd_pkg::SHIFT_W'(1);
                    cell_position_next = mfd_pkg::POS_W'(1);
                end
                mfd_pkg::OP_HIST_READ:
                begin
                    stage_out.has_result = 1'b1;
                    stage_out.is_count   = 1'b1;
                    if (bin_ext < RW'(HIST_BINS))
                    begin
                        stage_out.hist_op = mfd_pkg::HIST_CLEAR;
                    end
                end
                default: ;
            endcase
        end
    end

    assign s1_valid = in_valid_reg;

endmodule

// ===== sv/mfd_hist_stage.sv =====
// histogram read-modify-write stage with forwarding and clearing pass
`timescale 1ns / 1ps

module mfd_hist_stage #(
    parameter int HIST_BINS = mfd_pkg::HIST_BINS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mfd_pkg::mfd_stage_t          stage_in,
    input  logic [$clog2(HIST_BINS)-1:0] hist_addr,
    output logic                         s2_valid,
    output logic                         busy,
    output logic                         push,
    output mfd_pkg::mfd_result_t         result
);

    localparam int AW = $clog2(HIST_BINS);

    mfd_pkg::mfd_stage_t         stage_reg;
    logic [AW-1:0]               addr_reg;

    logic                        clear_busy_reg;
    logic [AW-1:0]               clear_addr_reg;

    logic                        last_we_reg;
    logic [AW-1:0]               last_waddr_reg;
    logic [mfd_pkg::COUNT_W-1:0] last_wdata_reg;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic [mfd_pkg::COUNT_W-1:0] wdata;
    logic [mfd_pkg::COUNT_W-1:0] rdata;
    logic [mfd_pkg::COUNT_W-1:0] count;

    mfd_ram #(
        .WIDTH (mfd_pkg::COUNT_W),
        .DEPTH (HIST_BINS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (hist_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg      <= '0;
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            last_we_reg    <= 1'b0;
        end
        else
        begin
            stage_reg   <= stage_in;
            last_we_reg <= we;
            if (clear_busy_reg)
            begin
                if (clear_addr_reg == AW'(HIST_BINS - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
                else
                begin
                    clear_addr_reg <= clear_addr_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= hist_addr;
        last_waddr_reg <= waddr;
        last_wdata_reg <= wdata;
    end

    // bin written on the previous edge is not yet in the read data
    assign count = (last_we_reg && last_waddr_reg == addr_reg) ? last_wdata_reg : rdata;

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = '0;
        if (clear_busy_reg)
        begin
            we    = 1'b1;
            waddr = clear_addr_reg;
        end
        else if (stage_reg.valid)
        begin
            case (stage_reg.hist_op)
                mfd_pkg::HIST_INC:
                begin
                    we    = 1'b1;
                    wdata = (count == '1) ? count : count + mfd_pkg::COUNT_W'(1);
                end
                mfd_pkg::HIST_CLEAR:
                begin
                    we = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign push             = stage_reg.valid && stage_reg.has_result;
    assign result.is_count  = stage_reg.is_count;
    assign result.data_byte = stage_reg.data_byte;
    assign result.bin_count = (stage_reg.hist_op == mfd_pkg::HIST_CLEAR) ? count : '0;
    assign s2_valid         = stage_reg.valid;
    assign busy             = clear_busy_reg;

endmodule

// ===== sv/mfd_out_fifo.sv =====
// small result queue between the pipeline and the output channel
`timescale 1ns / 1ps

module mfd_out_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  mfd_pkg::mfd_result_t              push_data,
    input  logic                              pop,
    output logic                              not_empty,
    output mfd_pkg::mfd_result_t              head,
    output logic [mfd_pkg::OUT_CNT_W-1:0]     count
);

    localparam int PW = $clog2(mfd_pkg::OUT_DEPTH);

    mfd_pkg::mfd_result_t         entry_reg [mfd_pkg::OUT_DEPTH];
    logic [PW-1:0]                wr_ptr_reg;
    logic [PW-1:0]                rd_ptr_reg;
    logic [mfd_pkg::OUT_CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + mfd_pkg::OUT_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - mfd_pkg::OUT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ===== sv/mfm_flux_interval_deserializer.sv =====
// top level of the mfm flux interval deserializer
//
//  channel   direction  fields (low bit up)                        transfer when
//  s_*       in         tuser: operation; tdata: edge_time,         s_tvalid && s_tready
//                       bin_index, zero fill
//  m_*       out        tuser: is_count; tdata: data_byte,          m_tvalid && m_tready
//                       bin_count
//  cfg_*     in         cfg_index selects register, cfg_data        cfg_we
//
// one item per cycle while s_tready is high
// the histogram memory read-modify-write takes two pipeline stages, with forwarding
// after reset a clearing pass over all HIST_BINS bins holds s_tready low
// up to four results are buffered; s_tready drops while four items are in flight
`timescale 1ns / 1ps

module mfm_flux_interval_deserializer #(
    parameter int HIST_BINS = mfd_pkg::HIST_BINS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // edge_time, bin_index, zero fill
    input  logic [mfd_pkg::OP_W-1:0]      s_tuser,   // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // data_byte, bin_count
    output logic                          m_tuser,   // is_count
    input  logic                          cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfd_pkg::LIMIT_W-1:0]   cfg_data
);

    localparam int AW = $clog2(HIST_BINS);

    logic                          accept;
    logic                          s1_valid;
    logic                          s2_valid;
    logic                          busy;
    logic                          push;
    logic                          pop;
    logic [mfd_pkg::OUT_CNT_W-1:0] fifo_count;
    logic [mfd_pkg::OUT_CNT_W-1:0] in_flight;
    logic [AW-1:0]                 hist_addr;
    mfd_pkg::mfd_stage_t           stage;
    mfd_pkg::mfd_result_t          result;
    mfd_pkg::mfd_result_t          head;

    assign in_flight = fifo_count + mfd_pkg::OUT_CNT_W'(s1_valid)
                       + mfd_pkg::OUT_CNT_W'(s2_valid);
    assign s_tready  = !busy && (in_flight < mfd_pkg::OUT_CNT_W'(mfd_pkg::OUT_DEPTH));
    assign accept    = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;

    mfd_edge_stage #(
        .HIST_BINS (HIST_BINS)
    ) u_edge_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (s_tuser),
        .edge_time (s_tdata[31:0]),
        .bin_index (s_tdata[41:32]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s1_valid  (s1_valid),
        .stage_out (stage),
        .hist_addr (hist_addr)
    );

    mfd_hist_stage #(
        .HIST_BINS (HIST_BINS)
    ) u_hist_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage_in  (stage),
        .hist_addr (hist_addr),
        .s2_valid  (s2_valid),
        .busy      (busy),
        .push      (push),
        .result    (result)
    );

    mfd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pop       (pop),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_tdata = {head.bin_count, head.data_byte};
    assign m_tuser = head.is_count;

endmodule

// ===== sim/tb_mfm_flux_interval_deserializer.sv =====
// self-checking testbench: directed and random stream traffic against a built-in flux decoder model
`timescale 1ns / 1ps

module tb_mfm_flux_interval_deserializer;

    localparam int HIST_BINS = mfd_pkg::HIST_BINS_DEFAULT;
    localparam int HIST_AW = $clog2(HIST_BINS);
    localparam logic [mfd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [mfd_pkg::OP_W-1:0]   op;
        logic [mfd_pkg::TIME_W-1:0] stamp;
        logic [mfd_pkg::BIN_W-1:0]  bin;
    } flux_item_t;

    typedef struct {
        logic [mfd_pkg::BYTE_W-1:0]  data_byte;
        logic [mfd_pkg::COUNT_W-1:0] bin_count;
        logic                        is_count;
    } flux_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [47:0]                   s_tdata = '0;   // edge_time, bin_index, zero fill
    logic [mfd_pkg::OP_W-1:0]      s_tuser = '0;   // operation
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [39:0]                   m_tdata;        // data_byte, bin_count
    logic                          m_tuser;        // is_count
    logic                          cfg_we = 1'b0;
    logic [mfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mfd_pkg::LIMIT_W-1:0]   cfg_data = '0;

    // decoder model state
    logic [mfd_pkg::LIMIT_W-1:0] lim_runt = mfd_pkg::RUNT_LIMIT_RESET;
    logic [mfd_pkg::LIMIT_W-1:0] lim_two = mfd_pkg::LIMIT_TWO_RESET;
    logic [mfd_pkg::LIMIT_W-1:0] lim_three = mfd_pkg::LIMIT_THREE_RESET;
    logic [mfd_pkg::LIMIT_W-1:0] lim_four = mfd_pkg::LIMIT_FOUR_RESET;
    logic [mfd_pkg::TIME_W-1:0]  prev_stamp = '0;
    logic [mfd_pkg::LIMIT_W-1:0] runt_carry = '0;
    logic [mfd_pkg::SHIFT_W-1:0] cell_bits = 12'd1;
    int                          cell_fill = 1;
    logic [mfd_pkg::COUNT_W-1:0] hist_bins [HIST_BINS];

    flux_item_t   pending_items [$];
    flux_result_t due_outputs [$];
    flux_item_t   cur_item;
    flux_result_t head_result;

    logic [mfd_pkg::TIME_W-1:0] gen_stamp = '0;
    int unsigned                recent_intervals [$];
    int                         send_gap = 0;
    int                         send_calm = 0;
    int                         recv_stall = 0;
    int                         recv_calm = 0;
    int                         fail_count = 0;
    int                         cycle_count = 0;

    mfm_flux_interval_deserializer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    task automatic decode_flux_item(input flux_item_t item);
        logic [mfd_pkg::TIME_W-1:0]  gap;
        logic [mfd_pkg::SHIFT_W-1:0] shifted;
        longint                      ivl;
        int                          cells;
        case (item.op)
            mfd_pkg::OP_EDGE:
            begin
                gap = item.stamp - prev_stamp;
                ivl = longint'(gap) + longint'(runt_carry);
                prev_stamp = item.stamp;
                if (ivl < longint'(HIST_BINS))
                begin
                    if (hist_bins[ivl[HIST_AW-1:0]] != '1)
                        hist_bins[ivl[HIST_AW-1:0]] = hist_bins[ivl[HIST_AW-1:0]] + 1;
                    if (ivl < longint'(lim_runt))
                        runt_carry = ivl[mfd_pkg::LIMIT_W-1:0];
                    else
                    begin
                        runt_carry = '0;
                        if (ivl < longint'(lim_two))
                            cells = 2;
                        else if (ivl < longint'(lim_three))
                            cells = 3;
                        else if (ivl < longint'(lim_four))
                            cells = 4;
                        else
                            cells = 0;
                        if (cells != 0)
                        begin
                            cell_bits = (cell_bits << cells) | mfd_pkg::SHIFT_W'(1);
                            cell_fill += cells;
                            if (cell_fill >= mfd_pkg::BYTE_CELLS)
                            begin
                                cell_fill -= mfd_pkg::BYTE_CELLS;
                                shifted = cell_bits >> cell_fill;
                                due_outputs.push_back('{
                                    data_byte: shifted[mfd_pkg::BYTE_W-1:0],
                                    bin_count: '0, is_count: 1'b0});
                            end
                        end
                    end
                end
            end
            mfd_pkg::OP_TRACK_START:
            begin
                prev_stamp = item.stamp;
                runt_carry = '0;
                cell_bits = 12'd1;
                cell_fill = 1;
            end
            mfd_pkg::OP_HIST_READ:
            begin
                due_outputs.push_back('{data_byte: '0, bin_count: hist_bins[item.bin],
                                        is_count: 1'b1});
                hist_bins[item.bin] = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int draw_pause(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_flux_item(cur_item);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_item.op;
                    s_tdata <= {6'b0, cur_item.bin, cur_item.stamp};
                    send_gap = draw_pause(send_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_outputs.size() == 0)
                    note_mismatch($sformatf("result %h user %b with nothing due",
                                            m_tdata, m_tuser));
                else
                begin
                    head_result = due_outputs.pop_front();
                    if (m_tdata[7:0] !== head_result.data_byte)
                        note_mismatch($sformatf("data_byte got %h want %h",
                                                m_tdata[7:0], head_result.data_byte));
                    if (m_tdata[39:8] !== head_result.bin_count)
                        note_mismatch($sformatf("bin_count got %h want %h",
                                                m_tdata[39:8], head_result.bin_count));
                    if (m_tuser !== head_result.is_count)
                        note_mismatch($sformatf("is_count got %b want %b",
                                                m_tuser, head_result.is_count));
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_stall = draw_pause(recv_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_item(input logic [mfd_pkg::OP_W-1:0] op,
                              input logic [mfd_pkg::TIME_W-1:0] stamp,
                              input logic [mfd_pkg::BIN_W-1:0] bin);
        pending_items.push_back('{op: op, stamp: stamp, bin: bin});
    endtask

    task automatic queue_edge(input int unsigned gap);
        gen_stamp = gen_stamp + gap;
        if (gap < HIST_BINS)
        begin
            recent_intervals.push_back(gap);
            if (recent_intervals.size() > 16)
                void'(recent_intervals.pop_front());
        end
        queue_item(mfd_pkg::OP_EDGE, gen_stamp, mfd_pkg::BIN_W'($urandom));
    endtask

    task automatic queue_track(input logic [mfd_pkg::TIME_W-1:0] stamp);
        gen_stamp = stamp;
        queue_item(mfd_pkg::OP_TRACK_START, stamp, mfd_pkg::BIN_W'($urandom));
    endtask

    task automatic queue_read(input logic [mfd_pkg::BIN_W-1:0] bin);
        queue_item(mfd_pkg::OP_HIST_READ, $urandom, bin);
    endtask

    function automatic int unsigned draw_interval();
        int unsigned edges_at [5];
        int          r;
        int          pick;
        int          runt;
        int          four;
        runt = int'(lim_runt);
        four = int'(lim_four);
        edges_at = '{32'(lim_runt), 32'(lim_two), 32'(lim_three), 32'(lim_four),
                     HIST_BINS};
        r = $urandom_range(0, 99);
        if (r < 15)
            return (runt == 0) ? 0 : $urandom_range(0, runt - 1);
        if (r < 70)
            return $urandom_range(runt, (four > runt) ? four - 1 : 1023);
        if (r < 90)
        begin
            pick = int'(edges_at[$urandom_range(0, 4)]) + int'($urandom_range(0, 4)) - 2;
            return (pick < 0) ? 0 : pick;
        end
        if (r < 95)
            return $urandom_range(1024, 4095);
        return $urandom();
    endfunction

    task automatic queue_random_items(input int count);
        int done;
        int r;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                queue_item(OP_UNUSED, $urandom, mfd_pkg::BIN_W'($urandom));
            else
            begin
                done++;
                if (r < 6)
                    queue_track($urandom);
                else if (r < 15)
                begin
                    if (recent_intervals.size() > 0 && $urandom_range(0, 3) != 0)
                        queue_read(mfd_pkg::BIN_W'(recent_intervals[$urandom_range(0,
                                   recent_intervals.size() - 1)]));
                    else
                        queue_read(mfd_pkg::BIN_W'($urandom));
                end
                else
                    queue_edge(draw_interval());
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid || due_outputs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mfd_pkg::LIMIT_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            mfd_pkg::CFG_RUNT_LIMIT:  lim_runt = val;
            mfd_pkg::CFG_LIMIT_TWO:   lim_two = val;
            mfd_pkg::CFG_LIMIT_THREE: lim_three = val;
            mfd_pkg::CFG_LIMIT_FOUR:  lim_four = val;
            default:                  lim_runt = lim_runt;
        endcase
    endtask

    task automatic write_limits(input int unsigned runt, two, three, four);
        write_reg(mfd_pkg::CFG_RUNT_LIMIT, mfd_pkg::LIMIT_W'(runt));
        write_reg(mfd_pkg::CFG_LIMIT_TWO, mfd_pkg::LIMIT_W'(two));
        write_reg(mfd_pkg::CFG_LIMIT_THREE, mfd_pkg::LIMIT_W'(three));
        write_reg(mfd_pkg::CFG_LIMIT_FOUR, mfd_pkg::LIMIT_W'(four));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned picks [$];
        foreach (hist_bins[i])
            hist_bins[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: class boundaries, runt merging, oversize, wrap, reads
        queue_track(32'hFFFF_FE00);
        queue_edge(239);
        queue_edge(161);
        queue_edge(240);
        queue_edge(399);
        queue_edge(400);
        queue_edge(559);
        queue_edge(560);
        queue_edge(719);
        queue_edge(720);
        queue_edge(1023);
        queue_edge(1024);
        queue_edge(0);
        queue_edge(100);
        queue_edge(1000);
        queue_edge(300);
        queue_item(OP_UNUSED, $urandom, mfd_pkg::BIN_W'($urandom));
        queue_read(240);
        queue_read(400);
        queue_read(1023);
        queue_read(0);
        queue_read(400);
        queue_track($urandom);
        queue_edge(600);
        queue_random_items(350);
        wait_idle();

        write_limits(0, 0, 0, 0);
        queue_random_items(80);
        wait_idle();

        write_limits(1023, 1023, 1023, 1023);
        queue_random_items(80);
        wait_idle();

        write_limits(100, 300, 600, 1023);
        queue_random_items(300);
        wait_idle();

        // thresholds out of order
        write_limits(500, 300, 700, 650);
        queue_random_items(250);
        wait_idle();

        write_limits(0, 1, 2, 1023);
        queue_random_items(100);
        wait_idle();

        repeat (4) picks.push_back($urandom_range(0, 1023));
        picks.sort();
        write_limits(picks[0], picks[1], picks[2], picks[3]);
        queue_random_items(250);
        wait_idle();

        write_limits(32'(mfd_pkg::RUNT_LIMIT_RESET), 32'(mfd_pkg::LIMIT_TWO_RESET),
                     32'(mfd_pkg::LIMIT_THREE_RESET), 32'(mfd_pkg::LIMIT_FOUR_RESET));
        queue_random_items(240);
        wait_idle();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
